### hdl/pfce_pkg.sv
// Shared types and constants for the palette flash and cycle engine.
// Depends on nothing; imported by the controller, datapath and top level.
`timescale 1ns / 1ps
package pfce_pkg;

    // request opcodes
    localparam logic [2:0] OP_TICK      = 3'd0;
    localparam logic [2:0] OP_PAL_WRITE = 3'd1;
    localparam logic [2:0] OP_PAL_READ  = 3'd2;
    localparam logic [2:0] OP_STEP_WR   = 3'd3;
    localparam logic [2:0] OP_FLASH_SET = 3'd4;
    localparam logic [2:0] OP_SHIFT_SET = 3'd5;

    localparam int RGB_W  = 24;
    localparam int DLY_W  = 16;
    localparam int CNT_W  = 17;
    localparam int STEP_W = DLY_W + RGB_W;

    // commands from controller to datapath
    typedef struct packed {
        logic clr;
        logic accept;
        logic rd_cap;
        logic fl_check;
        logic fl_write;
        logic fl_next;
        logic sh_check;
        logic sh_run;
        logic sh_end;
        logic sh_next;
        logic load_out;
    } pfce_cmd_t;

    // status from datapath to controller
    typedef struct packed {
        logic clr_last;
        logic fl_active;
        logic fl_adv;
        logic fl_last;
        logic sh_go;
        logic sh_at_end;
        logic sh_last;
        logic out_free;
    } pfce_stat_t;

endpackage

### hdl/pfce_ram.sv
// Generic simple dual-port RAM: one write port, one registered read port.
// No dependencies.
`timescale 1ns / 1ps
module pfce_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);
    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end
endmodule

### hdl/pfce_ctrl.sv
// Controller state machine: request handshake and tick sequencing.
// Depends on pfce_pkg; drives the datapath by pfce_cmd_t.
`timescale 1ns / 1ps
module pfce_ctrl
    import pfce_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    output logic       in_stall,
    input  logic [2:0] opcode,
    input  pfce_stat_t stat,
    output pfce_cmd_t  cmd
);
    typedef enum logic [10:0] {
        ST_CLR      = 11'b000_0000_0001,
        ST_IDLE     = 11'b000_0000_0010,
        ST_P_CAP    = 11'b000_0000_0100,
        ST_FL_RD    = 11'b000_0000_1000,
        ST_FL_CHK   = 11'b000_0001_0000,
        ST_FL_WR    = 11'b000_0010_0000,
        ST_SH_CHK   = 11'b000_0100_0000,
        ST_SH_RUN   = 11'b000_1000_0000,
        ST_SH_DRAIN = 11'b001_0000_0000,
        ST_SH_END   = 11'b010_0000_0000,
        ST_DONE     = 11'b100_0000_0000
    } state_t;

    state_t state_reg, state_next;

    // state register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_CLR;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // next state and commands
    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        in_stall   = 1'b1;
        unique case (state_reg)
            ST_CLR:
            begin
                cmd.clr = 1'b1;
                if (stat.clr_last)
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE:
            begin
                in_stall = 1'b0;
                if (in_valid)
                begin
                    cmd.accept = 1'b1;
                    if (opcode == OP_TICK)
                    begin
                        state_next = ST_FL_RD;
                    end
                    else if (opcode == OP_PAL_READ)
                    begin
                        state_next = ST_P_CAP;
                    end
                    else
                    begin
                        state_next = ST_DONE;
                    end
                end
            end
            ST_P_CAP:
            begin
                cmd.rd_cap = 1'b1;
                state_next = ST_DONE;
            end
            ST_FL_RD:
            begin
                if (stat.fl_active)
                begin
                    state_next = ST_FL_CHK;
                end
                else
                begin
                    cmd.fl_next = 1'b1;
                    state_next  = stat.fl_last ? ST_SH_CHK : ST_FL_RD;
                end
            end
            ST_FL_CHK:
            begin
                cmd.fl_check = 1'b1;
                if (stat.fl_adv)
                begin
                    state_next = ST_FL_WR;
                end
                else
                begin
                    cmd.fl_next = 1'b1;
                    state_next  = stat.fl_last ? ST_SH_CHK : ST_FL_RD;
                end
            end
            ST_FL_WR:
            begin
                cmd.fl_write = 1'b1;
                cmd.fl_next  = 1'b1;
                state_next   = stat.fl_last ? ST_SH_CHK : ST_FL_RD;
            end
            ST_SH_CHK:
            begin
                cmd.sh_check = 1'b1;
                if (stat.sh_go)
                begin
                    state_next = ST_SH_RUN;
                end
                else
                begin
                    cmd.sh_next = 1'b1;
                    state_next  = stat.sh_last ? ST_DONE : ST_SH_CHK;
                end
            end
            ST_SH_RUN:
            begin
                cmd.sh_run = 1'b1;
                if (stat.sh_at_end)
                begin
                    state_next = ST_SH_DRAIN;
                end
            end
            ST_SH_DRAIN:
            begin
                state_next = ST_SH_END;
            end
            ST_SH_END:
            begin
                cmd.sh_end  = 1'b1;
                cmd.sh_next = 1'b1;
                state_next  = stat.sh_last ? ST_DONE : ST_SH_CHK;
            end
            ST_DONE:
            begin
                if (stat.out_free)
                begin
                    cmd.load_out = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_CLR;
            end
        endcase
    end
endmodule

### hdl/pfce_datapath.sv
// Datapath: palette and flash step RAMs, channel registers, result register.
// Depends on pfce_pkg and pfce_ram; steered by pfce_ctrl.
`timescale 1ns / 1ps
module pfce_datapath
    import pfce_pkg::*;
#(
    parameter int FLASH_CHANNELS = 4,
    parameter int FLASH_STEPS    = 16,
    parameter int SHIFT_CHANNELS = 4,
    parameter int PALETTE_SIZE   = 256
) (
    input  logic             clk,
    input  logic             rst_n,
    input  pfce_cmd_t        cmd,
    output pfce_stat_t       stat,
    input  logic [2:0]       opcode,
    input  logic [1:0]       channel,
    input  logic [3:0]       step,
    input  logic [7:0]       color_index,
    input  logic [7:0]       range_end,
    input  logic [4:0]       step_count,
    input  logic [15:0]      delay,
    input  logic [23:0]      rgb,
    input  logic [1:0]       shift_kind,
    input  logic             shift_on,
    output logic             out_valid,
    input  logic             out_stall,
    output logic [23:0]      read_rgb,
    output logic             read_valid
);
    localparam int FCW  = (FLASH_CHANNELS > 1) ? $clog2(FLASH_CHANNELS) : 1;
    localparam int SCW  = (SHIFT_CHANNELS > 1) ? $clog2(SHIFT_CHANNELS) : 1;
    localparam int PAW  = $clog2(PALETTE_SIZE);
    localparam int POSW = $clog2(FLASH_STEPS);
    localparam int LENW = $clog2(FLASH_STEPS + 1);
    localparam int SDEP = FLASH_CHANNELS * FLASH_STEPS;
    localparam int SAW  = $clog2(SDEP);

    // flash channel registers
    logic [7:0]       fl_target_reg [FLASH_CHANNELS];
    logic [LENW-1:0]  fl_len_reg    [FLASH_CHANNELS];
    logic [POSW-1:0]  fl_pos_reg    [FLASH_CHANNELS];
    logic [CNT_W-1:0] fl_ctr_reg    [FLASH_CHANNELS];
    // shift channel registers
    logic [7:0]       sh_first_reg  [SHIFT_CHANNELS];
    logic [7:0]       sh_last_reg   [SHIFT_CHANNELS];
    logic [DLY_W-1:0] sh_dly_reg    [SHIFT_CHANNELS];
    logic [1:0]       sh_mode_reg   [SHIFT_CHANNELS];
    logic             sh_en_reg     [SHIFT_CHANNELS];
    logic [CNT_W-1:0] sh_ctr_reg    [SHIFT_CHANNELS];

    logic [FCW-1:0]   fc_reg;
    logic [SCW-1:0]   sc_reg;
    logic [PAW-1:0]   clr_ptr_reg;
    logic [PAW-1:0]   ptr_reg, end_reg, rd_ptr_reg;
    logic             down_reg, rot_reg, first_reg, rd_first_reg, rd_v_reg;
    logic [RGB_W-1:0] keep_reg;
    logic             rd_ok_reg;
    logic [RGB_W-1:0] res_rgb_reg, read_rgb_reg;
    logic             res_valid_reg, read_valid_reg, out_valid_reg;

    // RAM ports
    logic              pal_we;
    logic [PAW-1:0]    pal_waddr, pal_raddr;
    logic [RGB_W-1:0]  pal_wdata, pal_rdata;
    logic              st_we;
    logic [SAW-1:0]    st_waddr, st_raddr;
    logic [STEP_W-1:0] st_rdata;

    // flash step evaluation
    logic [CNT_W-1:0] fl_inc;
    logic [LENW-1:0]  fl_pos_p1;
    logic [POSW-1:0]  fl_newpos;
    logic             fl_adv;
    logic [LENW-1:0]  len_sat;
    // shift evaluation
    logic [CNT_W-1:0] sh_inc;
    logic             sh_fire;
    logic [PAW-1:0]   sh_lo, sh_hi;
    logic             sh_range_ok;
    logic             ch_fl_ok, ch_sh_ok, st_ok, idx_ok, tgt_ok;

    pfce_ram #(.WIDTH(RGB_W), .DEPTH(PALETTE_SIZE)) u_pal_ram (
        .clk   (clk),
        .we    (pal_we),
        .waddr (pal_waddr),
        .wdata (pal_wdata),
        .raddr (pal_raddr),
        .rdata (pal_rdata)
    );

    pfce_ram #(.WIDTH(STEP_W), .DEPTH(SDEP)) u_step_ram (
        .clk   (clk),
        .we    (st_we),
        .waddr (st_waddr),
        .wdata ({delay, rgb}),
        .raddr (st_raddr),
        .rdata (st_rdata)
    );

    // request decode helpers
    assign ch_fl_ok = int'(channel) < FLASH_CHANNELS;
    assign ch_sh_ok = int'(channel) < SHIFT_CHANNELS;
    assign st_ok    = int'(step) < FLASH_STEPS;
    assign idx_ok   = int'(color_index) < PALETTE_SIZE;
    assign tgt_ok   = int'(fl_target_reg[fc_reg]) < PALETTE_SIZE;
    assign len_sat  = (int'(step_count) > FLASH_STEPS) ? LENW'(FLASH_STEPS)
                                                       : LENW'(step_count);

    // flash compare and next position
    assign fl_inc    = fl_ctr_reg[fc_reg] + CNT_W'(1);
    assign fl_adv    = fl_inc > CNT_W'(st_rdata[STEP_W-1:RGB_W]);
    assign fl_pos_p1 = LENW'(fl_pos_reg[fc_reg]) + LENW'(1);
    assign fl_newpos = (fl_pos_p1 == fl_len_reg[fc_reg]) ? '0 : POSW'(fl_pos_p1);

    // shift compare and clipped range
    assign sh_inc      = sh_ctr_reg[sc_reg] + CNT_W'(1);
    assign sh_fire     = sh_en_reg[sc_reg] && (sh_inc > CNT_W'(sh_dly_reg[sc_reg]));
    assign sh_lo       = PAW'(sh_first_reg[sc_reg]);
    assign sh_hi       = (int'(sh_last_reg[sc_reg]) >= PALETTE_SIZE)
                         ? PAW'(PALETTE_SIZE - 1) : PAW'(sh_last_reg[sc_reg]);
    assign sh_range_ok = (int'(sh_first_reg[sc_reg]) < PALETTE_SIZE) && (sh_hi >= sh_lo);

    // step RAM addressing
    always_comb
    begin
        st_we    = cmd.accept && (opcode == OP_STEP_WR) && ch_fl_ok && st_ok;
        st_waddr = SAW'(SAW'(channel) * SAW'(FLASH_STEPS)) + SAW'(step);
        if (cmd.fl_check)
        begin
            st_raddr = SAW'(SAW'(fc_reg) * SAW'(FLASH_STEPS)) + SAW'(fl_newpos);
        end
        else
        begin
            st_raddr = SAW'(SAW'(fc_reg) * SAW'(FLASH_STEPS)) + SAW'(fl_pos_reg[fc_reg]);
        end
    end

    // palette RAM addressing; the sources never overlap in time
    always_comb
    begin
        pal_we    = 1'b0;
        pal_waddr = PAW'(color_index);
        pal_wdata = rgb;
        pal_raddr = cmd.sh_run ? ptr_reg : PAW'(color_index);
        if (cmd.clr)
        begin
            pal_we    = 1'b1;
            pal_waddr = clr_ptr_reg;
            pal_wdata = '0;
        end
        else if (cmd.accept && (opcode == OP_PAL_WRITE))
        begin
            pal_we = idx_ok;
        end
        else if (cmd.fl_write)
        begin
            pal_we    = tgt_ok;
            pal_waddr = PAW'(fl_target_reg[fc_reg]);
            pal_wdata = st_rdata[RGB_W-1:0];
        end
        else if (rd_v_reg && !rd_first_reg)
        begin
            pal_we    = 1'b1;
            pal_waddr = down_reg ? (rd_ptr_reg - PAW'(1)) : (rd_ptr_reg + PAW'(1));
            pal_wdata = pal_rdata;
        end
        else if (cmd.sh_end)
        begin
            pal_we    = rot_reg;
            pal_waddr = end_reg;
            pal_wdata = keep_reg;
        end
    end

    // status to controller
    always_comb
    begin
        stat.clr_last  = clr_ptr_reg == PAW'(PALETTE_SIZE - 1);
        stat.fl_active = fl_len_reg[fc_reg] != '0;
        stat.fl_adv    = fl_adv;
        stat.fl_last   = fc_reg == FCW'(FLASH_CHANNELS - 1);
        stat.sh_go     = sh_fire && sh_range_ok;
        stat.sh_at_end = ptr_reg == end_reg;
        stat.sh_last   = sc_reg == SCW'(SHIFT_CHANNELS - 1);
        stat.out_free  = !out_valid_reg || !out_stall;
    end

    // channel state, sequencing and result registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < FLASH_CHANNELS; i++)
            begin
                fl_target_reg[i] <= '0;
                fl_len_reg[i]    <= '0;
                fl_pos_reg[i]    <= '0;
                fl_ctr_reg[i]    <= '0;
            end
            for (int i = 0; i < SHIFT_CHANNELS; i++)
            begin
                sh_first_reg[i] <= '0;
                sh_last_reg[i]  <= '0;
                sh_dly_reg[i]   <= '0;
                sh_mode_reg[i]  <= '0;
                sh_en_reg[i]    <= 1'b0;
                sh_ctr_reg[i]   <= '0;
            end
            fc_reg         <= '0;
            sc_reg         <= '0;
            clr_ptr_reg    <= '0;
            ptr_reg        <= '0;
            end_reg        <= '0;
            rd_ptr_reg     <= '0;
            down_reg       <= 1'b0;
            rot_reg        <= 1'b0;
            first_reg      <= 1'b0;
            rd_first_reg   <= 1'b0;
            rd_v_reg       <= 1'b0;
            keep_reg       <= '0;
            rd_ok_reg      <= 1'b0;
            res_rgb_reg    <= '0;
            res_valid_reg  <= 1'b0;
            read_rgb_reg   <= '0;
            read_valid_reg <= 1'b0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            // clearing pass
            if (cmd.clr)
            begin
                clr_ptr_reg <= clr_ptr_reg + PAW'(1);
            end

            // request accept: setup writes and result defaults
            if (cmd.accept)
            begin
                fc_reg        <= '0;
                sc_reg        <= '0;
                rd_ok_reg     <= idx_ok;
                res_rgb_reg   <= '0;
                res_valid_reg <= opcode == OP_PAL_READ;
                if ((opcode == OP_FLASH_SET) && ch_fl_ok)
                begin
                    fl_target_reg[FCW'(channel)] <= color_index;
                    fl_len_reg[FCW'(channel)]    <= len_sat;
                    fl_pos_reg[FCW'(channel)]    <= '0;
                    fl_ctr_reg[FCW'(channel)]    <= '0;
                end
                if ((opcode == OP_SHIFT_SET) && ch_sh_ok)
                begin
                    sh_first_reg[SCW'(channel)] <= color_index;
                    sh_last_reg[SCW'(channel)]  <= range_end;
                    sh_dly_reg[SCW'(channel)]   <= delay;
                    sh_mode_reg[SCW'(channel)]  <= shift_kind;
                    sh_en_reg[SCW'(channel)]    <= shift_on;
                    sh_ctr_reg[SCW'(channel)]   <= '0;
                end
            end

            // palette read capture
            if (cmd.rd_cap)
            begin
                res_rgb_reg <= rd_ok_reg ? pal_rdata : '0;
            end

            // flash counter and position update
            if (cmd.fl_check)
            begin
                fl_ctr_reg[fc_reg] <= fl_adv ? '0 : fl_inc;
                if (fl_adv)
                begin
                    fl_pos_reg[fc_reg] <= fl_newpos;
                end
            end
            if (cmd.fl_next)
            begin
                fc_reg <= fc_reg + FCW'(1);
            end

            // shift counter and range walk setup
            if (cmd.sh_check && sh_en_reg[sc_reg])
            begin
                sh_ctr_reg[sc_reg] <= sh_fire ? '0 : sh_inc;
            end
            if (cmd.sh_check)
            begin
                down_reg  <= sh_mode_reg[sc_reg][1];
                rot_reg   <= sh_mode_reg[sc_reg][0];
                ptr_reg   <= sh_mode_reg[sc_reg][1] ? sh_lo : sh_hi;
                end_reg   <= sh_mode_reg[sc_reg][1] ? sh_hi : sh_lo;
                first_reg <= 1'b1;
            end

            // streaming walk: one read issued per cycle, data written next cycle
            rd_v_reg <= cmd.sh_run;
            if (cmd.sh_run)
            begin
                rd_ptr_reg   <= ptr_reg;
                rd_first_reg <= first_reg;
                first_reg    <= 1'b0;
                if (ptr_reg != end_reg)
                begin
                    ptr_reg <= down_reg ? (ptr_reg + PAW'(1)) : (ptr_reg - PAW'(1));
                end
            end
            if (rd_v_reg && rd_first_reg)
            begin
                keep_reg <= pal_rdata;
            end
            if (cmd.sh_next)
            begin
                sc_reg <= sc_reg + SCW'(1);
            end

            // output register
            if (cmd.load_out)
            begin
                out_valid_reg  <= 1'b1;
                read_rgb_reg   <= res_rgb_reg;
                read_valid_reg <= res_valid_reg;
            end
            else if (!out_stall)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    assign out_valid  = out_valid_reg;
    assign read_rgb   = read_rgb_reg;
    assign read_valid = read_valid_reg;
endmodule

### hdl/palette_flash_and_cycle_engine_unit.sv
// Palette flash and colour-cycling engine, top level.
// Write/setup requests go from ST_IDLE to ST_DONE; a palette read also passes ST_P_CAP.
// Tick: each flash channel is checked in turn, then each shift channel; a firing shift
// channel walks its palette range with the one-entry-per-cycle palette RAM walk.
// One request in flight; the next is accepted once the result is registered.
// Reset: async active low; then a clearing pass writes zero to every palette entry.
`timescale 1ns / 1ps
module palette_flash_and_cycle_engine_unit
    import pfce_pkg::*;
#(
    parameter int FLASH_CHANNELS = 4,
    parameter int FLASH_STEPS    = 16,
    parameter int SHIFT_CHANNELS = 4,
    parameter int PALETTE_SIZE   = 256
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic [2:0]  opcode,
    input  logic [1:0]  channel,
    input  logic [3:0]  step,
    input  logic [7:0]  color_index,
    input  logic [7:0]  range_end,
    input  logic [4:0]  step_count,
    input  logic [15:0] delay,
    input  logic [23:0] rgb,
    input  logic [1:0]  shift_kind,
    input  logic        shift_on,
    output logic        out_valid,
    input  logic        out_stall,
    output logic [23:0] read_rgb,
    output logic        read_valid
);
    pfce_cmd_t  cmd;
    pfce_stat_t stat;

    pfce_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_stall (in_stall),
        .opcode   (opcode),
        .stat     (stat),
        .cmd      (cmd)
    );

    pfce_datapath #(
        .FLASH_CHANNELS (FLASH_CHANNELS),
        .FLASH_STEPS    (FLASH_STEPS),
        .SHIFT_CHANNELS (SHIFT_CHANNELS),
        .PALETTE_SIZE   (PALETTE_SIZE)
    ) u_dp (
        .clk         (clk),
        .rst_n       (rst_n),
        .cmd         (cmd),
        .stat        (stat),
        .opcode      (opcode),
        .channel     (channel),
        .step        (step),
        .color_index (color_index),
        .range_end   (range_end),
        .step_count  (step_count),
        .delay       (delay),
        .rgb         (rgb),
        .shift_kind  (shift_kind),
        .shift_on    (shift_on),
        .out_valid   (out_valid),
        .out_stall   (out_stall),
        .read_rgb    (read_rgb),
        .read_valid  (read_valid)
    );
endmodule

### hdl/pfce_checker.sv
// Port-level checker for the palette flash and cycle engine, bound to the top.
// No dependencies beyond the top level's port names.
`timescale 1ns / 1ps
module pfce_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        in_valid,
    input logic        in_stall,
    input logic        out_valid,
    input logic        out_stall,
    input logic [23:0] read_rgb,
    input logic        read_valid
);
    // a stalled result stays offered
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid)
        else $error("result dropped while stalled");

    // a stalled result keeps its payload
    a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> $stable(read_rgb) && $stable(read_valid))
        else $error("result payload changed while stalled");

    // non-read results carry no colour
    a_zero_rgb: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !read_valid |-> read_rgb == 24'd0)
        else $error("non-read result with nonzero colour");

    // a new result never appears while input side is open
    a_busy_before_result: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid) |-> $past(in_stall))
        else $error("result appeared without a request in flight");
endmodule

bind palette_flash_and_cycle_engine_unit pfce_checker u_pfce_checker (.*);
